// ===== rtl/ordered_segment_table_core_macros.svh =====
// Assertion macros shared by the ordered segment table RTL.
`ifndef ORDERED_SEGMENT_TABLE_CORE_MACROS_SVH
`define ORDERED_SEGMENT_TABLE_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define OST_ASSERT_HOLDS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define OST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ost_pkg.sv =====
// Types, constants and helpers of the ordered segment table.
package ost_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int SEQ_W       = 32;
  localparam int LEN_W       = 16;
  localparam int HDL_W       = 16;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_POP      = 2'd1,
    CMD_FIND     = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // One stored segment
  typedef struct packed {
    logic [SEQ_W-1:0] seq_start;
    logic [SEQ_W-1:0] seq_end;
    logic [LEN_W-1:0] length;
    logic [HDL_W-1:0] handle;
  } entry_t;

  // Table memory port request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // One result beat
  typedef struct packed {
    status_e                status;
    logic                   found;
    entry_t                 entry;
    logic [COUNT_OUT_W-1:0] count;
  } result_t;

  // Controller status seen by the top level
  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } ctrl_stat_t;

  // Logical slot (offset from head) to physical address in the ring
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] lidx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(lidx);
    if (sum >= SUM_W'(TABLE_DEPTH)) begin
      sum = sum - SUM_W'(TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/ost_mem.sv =====
// Segment storage: one write port, one registered read port.
module ost_mem (
  input  logic              clk_i,
  input  ost_pkg::mem_req_t req_i,
  output ost_pkg::entry_t   rdata_o
);
  import ost_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  // Write and read; read data is valid in the next cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ost_ctrl.sv =====
// Command sequencer: walks, shifts and updates the ring-ordered table.
module ost_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  ost_pkg::cmd_e       cmd_i,
  input  ost_pkg::entry_t     item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ost_pkg::result_t    res_o,
  output ost_pkg::mem_req_t   mem_req_o,
  input  ost_pkg::entry_t     mem_rdata_i,
  output ost_pkg::ctrl_stat_t stat_o
);
  import ost_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDH   = 4'd1;
  localparam logic [3:0] S_CHKH  = 4'd2;
  localparam logic [3:0] S_CHKT  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_WNEW  = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] wr_idx_q, wr_idx_d;
  logic             wr_pend_q, wr_pend_d;
  logic             rd_more_q, rd_more_d;
  cmd_e             cmd_q, cmd_d;
  entry_t           item_q, item_d;
  entry_t           prev_q, prev_d;
  result_t          res_q, res_d;

  entry_t           rd;
  logic [CNT_W-1:0] last_idx;
  logic             at_last;

  function automatic result_t mk_res(input status_e st, input logic hit, input entry_t ent);
    result_t r;
    r.status = st;
    r.found  = hit;
    r.entry  = hit ? ent : '0;
    r.count  = '0;
    return r;
  endfunction

  assign rd       = mem_rdata_i;
  assign last_idx = cnt_q - CNT_W'(1);
  assign at_last  = (idx_q == last_idx);

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    wr_idx_d  = wr_idx_q;
    wr_pend_d = wr_pend_q;
    rd_more_d = rd_more_q;
    cmd_d     = cmd_q;
    item_d    = item_q;
    prev_d    = prev_q;
    res_d     = res_q;
    mem_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          item_d = item_i;
          if (cmd_i == CMD_INSERT) begin
            if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
              res_d   = mk_res(ST_FULL, 1'b0, '0);
              state_d = S_DONE;
            end else if (cnt_q == '0) begin
              pos_d   = '0;
              state_d = S_WNEW;
            end else begin
              state_d = S_RDH;
            end
          end else if (cnt_q == '0) begin
            res_d   = mk_res(ST_EMPTY, 1'b0, '0);
            state_d = S_DONE;
          end else begin
            state_d = S_RDH;
          end
        end
      end

      // Fetch the head entry
      S_RDH: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = phys_addr(head_q, '0);
        idx_d           = '0;
        unique case (cmd_q)
          CMD_INSERT:             state_d = S_CHKH;
          CMD_POP:                state_d = S_POP;
          CMD_FIND, CMD_CONTAINS: state_d = S_SCAN;
          default:                state_d = S_SCAN;
        endcase
      end

      // Insert before head, reject an overlap, or go check the tail
      S_CHKH: begin
        if (item_q.seq_start < rd.seq_start) begin
          if (rd.seq_start < item_q.seq_end) begin
            res_d   = mk_res(ST_REJECT, 1'b0, '0);
            state_d = S_DONE;
          end else begin
            head_d  = (head_q == '0) ? IDX_W'(TABLE_DEPTH - 1) : head_q - IDX_W'(1);
            pos_d   = '0;
            state_d = S_WNEW;
          end
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = phys_addr(head_q, last_idx);
          state_d         = S_CHKT;
        end
      end

      // Append after tail, reject an overlap, or walk from the head
      S_CHKT: begin
        if (rd.seq_start < item_q.seq_start) begin
          if (item_q.seq_start < rd.seq_end) begin
            res_d   = mk_res(ST_REJECT, 1'b0, '0);
            state_d = S_DONE;
          end else begin
            pos_d   = cnt_q;
            state_d = S_WNEW;
          end
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = phys_addr(head_q, '0);
          idx_d           = '0;
          state_d         = S_WALK;
        end
      end

      // rd is entry idx, prev_q is entry idx-1
      S_WALK: begin
        if (idx_q != '0 &&
            (item_q.seq_start == prev_q.seq_start || item_q.seq_start < prev_q.seq_end)) begin
          res_d   = mk_res(ST_REJECT, 1'b0, '0);
          state_d = S_DONE;
        end else if (idx_q != '0 && item_q.seq_start < rd.seq_start) begin
          if (rd.seq_start < item_q.seq_end) begin
            res_d   = mk_res(ST_REJECT, 1'b0, '0);
            state_d = S_DONE;
          end else begin
            pos_d     = idx_q;
            idx_d     = last_idx;
            rd_more_d = 1'b1;
            wr_pend_d = 1'b0;
            state_d   = S_SHIFT;
          end
        end else begin
          prev_d = rd;
          if (at_last) begin
            res_d   = mk_res(ST_REJECT, 1'b0, '0);
            state_d = S_DONE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = phys_addr(head_q, idx_q + CNT_W'(1));
            idx_d           = idx_q + CNT_W'(1);
          end
        end
      end

      // Move entries pos..n-1 up one slot, read k while writing k+2
      S_SHIFT: begin
        if (wr_pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = phys_addr(head_q, wr_idx_q);
          mem_req_o.wdata = rd;
        end
        if (rd_more_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = phys_addr(head_q, idx_q);
          wr_pend_d       = 1'b1;
          wr_idx_d        = idx_q + CNT_W'(1);
          idx_d           = idx_q - CNT_W'(1);
          rd_more_d       = (idx_q != pos_q);
        end else begin
          wr_pend_d = 1'b0;
          state_d   = S_WNEW;
        end
      end

      // Store the new segment
      S_WNEW: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = phys_addr(head_q, pos_q);
        mem_req_o.wdata = item_q;
        cnt_d           = cnt_q + CNT_W'(1);
        res_d           = mk_res(ST_OK, 1'b0, '0);
        state_d         = S_DONE;
      end

      // Pop: advance head
      S_POP: begin
        res_d   = mk_res(ST_OK, 1'b1, rd);
        head_d  = (head_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = S_DONE;
      end

      // Find next after key, or contains end key
      S_SCAN: begin
        if (cmd_q == CMD_FIND) begin
          if (rd.seq_start > item_q.seq_start) begin
            res_d   = mk_res(ST_OK, 1'b1, rd);
            state_d = S_DONE;
          end else if (at_last) begin
            res_d   = mk_res(ST_OK, 1'b0, '0);
            state_d = S_DONE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = phys_addr(head_q, idx_q + CNT_W'(1));
            idx_d           = idx_q + CNT_W'(1);
          end
        end else begin
          if (rd.seq_end < item_q.seq_end) begin
            if (at_last) begin
              res_d   = mk_res(ST_OK, 1'b0, '0);
              state_d = S_DONE;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = phys_addr(head_q, idx_q + CNT_W'(1));
              idx_d           = idx_q + CNT_W'(1);
            end
          end else begin
            res_d   = mk_res(ST_OK, rd.seq_end == item_q.seq_end, rd);
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      wr_idx_q  <= '0;
      wr_pend_q <= 1'b0;
      rd_more_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      wr_idx_q  <= wr_idx_d;
      wr_pend_q <= wr_pend_d;
      rd_more_q <= rd_more_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    item_q <= item_d;
    prev_q <= prev_d;
    res_q  <= res_d;
  end

  // Result with the post-command count
  always_comb begin
    res_o       = res_q;
    res_o.count = COUNT_OUT_W'(cnt_q);
  end

  assign res_valid_o  = (state_q == S_DONE);
  assign stat_o.idle  = (state_q == S_IDLE);
  assign stat_o.count = cnt_q;

endmodule

// ===== rtl/ordered_segment_table_core.sv =====
// Ordered segment table: sorted segment store for out-of-order reassembly.
//
// Slave stream carries one command per beat: tuser selects insert, pop head,
// find first start above key, or contains end key; tdata carries start, end,
// length and buffer handle. Master stream returns exactly one result beat per
// command: tuser holds status and found, tdata the entry and the count.
// Entries sit in a 16-deep ring memory with registered reads.
// One command is processed at a time; s_axis_tready is high while idle.
// An insert runs head and tail checks, a walk of one entry per cycle to the
// slot, then a one-slot shift per cycle from the tail back to it, then the
// write; pop reads the head entry, and find and contains scan from the head.
// Full or empty rejections are answered straight from idle. The walk and the
// shift go through the single memory read port. With the receiver ready, the
// sequencer returns to idle after each result, then takes the next command.
// A result register decouples the output: a new command is accepted while a
// result waits; the sequencer holds its next result until the register frees.
// Reset empties the table at once; no clearing pass is needed.
module ordered_segment_table_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] seq_start, [63:32] seq_end, [79:64] length, [95:80] buffer_handle
  input  logic [95:0]  s_axis_tdata,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] entry_start, [63:32] entry_end, [79:64] entry_length,
  // [95:80] entry_handle, [100:96] entry_count, [103:101] zero
  output logic [103:0] m_axis_tdata,
  // [1:0] status, [2] found
  output logic [2:0]   m_axis_tuser
);
  import ost_pkg::*;

  `include "ordered_segment_table_core_macros.svh"

  entry_t     item;
  result_t    res;
  logic       res_valid;
  logic       res_ready;
  mem_req_t   mem_req;
  entry_t     mem_rdata;
  ctrl_stat_t ctrl_stat;
  logic       m_valid_q;
  result_t    m_res_q;
  logic       out_full;
  logic       out_full_cnt;
  logic       out_hit;

  // Unpack the command beat
  assign item.seq_start = s_axis_tdata[31:0];
  assign item.seq_end   = s_axis_tdata[63:32];
  assign item.length    = s_axis_tdata[79:64];
  assign item.handle    = s_axis_tdata[95:80];

  assign s_axis_tready = ctrl_stat.idle;

  ost_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .stat_o      (ctrl_stat)
  );

  ost_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = {m_res_q.found, m_res_q.status};
  assign m_axis_tdata  = {3'b000, m_res_q.count, m_res_q.entry.handle,
                          m_res_q.entry.length, m_res_q.entry.seq_end,
                          m_res_q.entry.seq_start};

  // Checks
  assign out_full     = m_valid_q && (m_res_q.status == ST_FULL);
  assign out_full_cnt = (m_res_q.count == COUNT_OUT_W'(TABLE_DEPTH));
  assign out_hit      = m_valid_q && m_res_q.found;

  `OST_ASSERT_HOLDS(a_count_bound, ctrl_stat.count <= CNT_W'(TABLE_DEPTH), "count over depth")
  `OST_ASSERT_IMP(a_full_count, out_full, out_full_cnt, "full status with table not full")
  `OST_ASSERT_IMP(a_found_ok, out_hit, m_res_q.status == ST_OK, "hit with non-ok status")
  `OST_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after accept")

endmodule
